// ----- sv/dlpw_pkg.sv -----
// shared types, constants and register map of the line pixel writer
package dlpw_pkg;

  localparam int DEFAULT_COORD_BITS = 12;
  localparam int ADDR_BITS          = 26;
  localparam int WORD_BITS          = 32;
  localparam int CHAN_BITS          = 8;
  localparam int OFFSET_BITS        = 5;
  localparam int STRIDE_BITS        = 15;
  localparam int HEIGHT_BITS        = 13;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int CFG_DATA_BITS      = 15;

  // register map
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_OFFSET   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_OFFSET  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_STRIDE   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd5;

  // register reset values
  localparam logic [OFFSET_BITS-1:0] RST_RED_OFFSET   = 5'd16;
  localparam logic [OFFSET_BITS-1:0] RST_GREEN_OFFSET = 5'd8;
  localparam logic [OFFSET_BITS-1:0] RST_BLUE_OFFSET  = 5'd0;
  localparam logic [OFFSET_BITS-1:0] RST_ALPHA_OFFSET = 5'd24;
  localparam logic [STRIDE_BITS-1:0] RST_ROW_STRIDE   = 15'd2560;
  localparam logic [HEIGHT_BITS-1:0] RST_SCREEN_HEIGHT = 13'd480;

  // request codes
  localparam logic REQ_LINE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POS,
    ST_EMIT
  } state_t;

  // places one colour channel at its bit offset, bits past the top are lost
  function automatic logic [WORD_BITS-1:0] place_chan(input logic [CHAN_BITS-1:0] chan,
                                                      input logic [OFFSET_BITS-1:0] off);
    logic [WORD_BITS-1:0] wide;
    wide = {{(WORD_BITS-CHAN_BITS){1'b0}}, chan};
    return wide << off;
  endfunction

endpackage

// ----- sv/dlpw_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module dlpw_div import dlpw_pkg::*; #(
  parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2*COORD_BITS-1:0] dividend,
  input  logic [COORD_BITS-1:0]   divisor,
  output logic                    done,
  output logic [COORD_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(COORD_BITS);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dvd;
  logic [COORD_BITS:0]   trial;
  logic                  fits;

  // the high half of the dividend is below the divisor, so the quotient fits
  assign trial = {rem, dvd[COORD_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(COORD_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(COORD_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*COORD_BITS-1:COORD_BITS];
      dvd <= dividend[COORD_BITS-1:0];
    end else if (busy) begin
      rem      <= fits ? COORD_BITS'(trial - {1'b0, divisor}) : trial[COORD_BITS-1:0];
      dvd      <= {dvd[COORD_BITS-2:0], 1'b0};
      quotient <= {quotient[COORD_BITS-2:0], fits};
    end
  end

endmodule

// ----- sv/dda_line_pixel_writer.sv -----
// top level of the line rasterizer that emits framebuffer pixel writes
//
// usage:
// - input channel (in_valid/in_ready): req_type 0 is a line command that
//   latches the endpoints and packs the colour at the current channel offsets;
//   it gives no result. req_type 1 is a tick: while a line is drawing it
//   yields one pixel write, otherwise it is dropped without a result.
// - output channel (out_valid/out_ready): byte_address, pixel_word, in_bounds
//   and last_pixel of one pixel; a transfer takes the result out of the
//   output register.
// - config port: cfg_write with cfg_index/cfg_data, taken at once; write it
//   only while the block is idle.
// - a command is accepted in the idle state and leaves the block ready. a tick
//   that draws goes through these steps to a valid result: the two step
//   products are registered, the serial dividers are loaded, they form
//   their quotient bits (x and y side by side), the results are handed
//   over, then the point and the row/column address are registered in turn.
// - no new item is taken while a pixel is being worked out; commands and
//   dropped ticks go one per cycle while the block is idle.
// - stall: a finished pixel waits in the output register while the next
//   item is accepted; only the following pixel waits for the transfer.
// - reset: drawing stops, output goes empty, registers take reset values.
module dda_line_pixel_writer import dlpw_pkg::*; #(
  parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [COORD_BITS-1:0]     start_x,
  input  logic [COORD_BITS-1:0]     start_y,
  input  logic [COORD_BITS-1:0]     end_x,
  input  logic [COORD_BITS-1:0]     end_y,
  input  logic [CHAN_BITS-1:0]      red,
  input  logic [CHAN_BITS-1:0]      green,
  input  logic [CHAN_BITS-1:0]      blue,
  input  logic [CHAN_BITS-1:0]      alpha,
  // pixel write channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ADDR_BITS-1:0]      byte_address,
  output logic [WORD_BITS-1:0]      pixel_word,
  output logic                      in_bounds,
  output logic                      last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + HEIGHT_BITS;  // wide enough to compare y with height
  localparam int RB = HEIGHT_BITS + STRIDE_BITS; // row offset product

  // configuration registers
  logic [OFFSET_BITS-1:0] red_offset, green_offset, blue_offset, alpha_offset;
  logic [STRIDE_BITS-1:0] row_stride;
  logic [HEIGHT_BITS-1:0] screen_height;

  // line state
  logic                 drawing;
  logic [CB-1:0]        origin_x, origin_y;
  logic [CB-1:0]        abs_x, abs_y;
  logic                 neg_x, neg_y;
  logic [CB-1:0]        run_length;
  logic [CB-1:0]        step_count;
  logic [WORD_BITS-1:0] color_word;

  // per-pixel work registers
  logic [2*CB-1:0]      prod_x, prod_y;
  logic                 last_r;
  logic [CB-1:0]        pos_x;
  logic [HEIGHT_BITS-1:0] pos_row;
  logic                 pos_inb;

  state_t state, state_next;
  logic   in_accept, line_accept, tick_go, emit_load;
  logic   div_start, div_done_x, div_done_y;
  logic [CB-1:0] quo_x, quo_y;

  // command decode of deltas
  logic [CB:0]   dx, dy;
  logic [CB-1:0] ax, ay;

  assign in_accept   = in_valid && in_ready;
  assign line_accept = in_accept && (req_type == REQ_LINE);

  always_comb begin
    dx = {1'b0, end_x} - {1'b0, start_x};
    dy = {1'b0, end_y} - {1'b0, start_y};
    ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    tick_go    = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        tick_go  = in_valid && (req_type == REQ_TICK) && drawing;
        if (tick_go) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done_x && div_done_y) begin
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        emit_load = !out_valid || out_ready;
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      red_offset    <= RST_RED_OFFSET;
      green_offset  <= RST_GREEN_OFFSET;
      blue_offset   <= RST_BLUE_OFFSET;
      alpha_offset  <= RST_ALPHA_OFFSET;
      row_stride    <= RST_ROW_STRIDE;
      screen_height <= RST_SCREEN_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RED_OFFSET:    red_offset    <= cfg_data[OFFSET_BITS-1:0];
        REG_GREEN_OFFSET:  green_offset  <= cfg_data[OFFSET_BITS-1:0];
        REG_BLUE_OFFSET:   blue_offset   <= cfg_data[OFFSET_BITS-1:0];
        REG_ALPHA_OFFSET:  alpha_offset  <= cfg_data[OFFSET_BITS-1:0];
        REG_ROW_STRIDE:    row_stride    <= cfg_data[STRIDE_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // line state: a command restarts it, a drawing tick advances it
  always_ff @(posedge clk) begin
    if (rst) begin
      drawing <= 1'b0;
    end else if (line_accept) begin
      drawing <= 1'b1;
    end else if (tick_go && (step_count >= run_length)) begin
      drawing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_accept) begin
      origin_x   <= start_x;
      origin_y   <= start_y;
      neg_x      <= dx[CB];
      neg_y      <= dy[CB];
      abs_x      <= ax;
      abs_y      <= ay;
      run_length <= (ax > ay) ? ax : ay;
      step_count <= '0;
      color_word <= place_chan(red, red_offset) | place_chan(green, green_offset) |
                    place_chan(blue, blue_offset) | place_chan(alpha, alpha_offset);
    end else if (tick_go) begin
      // step products i*|d| feed the dividers next cycle
      prod_x <= {{CB{1'b0}}, step_count} * {{CB{1'b0}}, abs_x};
      prod_y <= {{CB{1'b0}}, step_count} * {{CB{1'b0}}, abs_y};
      last_r <= step_count >= run_length;
      if (step_count < run_length) begin
        step_count <= step_count + 1'b1;
      end
    end
  end

  // dividers start the cycle after the products settle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= tick_go;
    end
  end

  dlpw_div #(.COORD_BITS(CB)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_x),
    .divisor  (run_length),
    .done     (div_done_x),
    .quotient (quo_x)
  );

  dlpw_div #(.COORD_BITS(CB)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_y),
    .divisor  (run_length),
    .done     (div_done_y),
    .quotient (quo_y)
  );

  // point, bounds check and flipped row
  logic [CB-1:0] mag_x, mag_y, pt_x, pt_y;
  logic [CW-1:0] y_wide, h_wide, row_wide;

  always_comb begin
    // zero-length line: quotient is meaningless, the point is the origin
    mag_x    = (run_length == '0) ? '0 : quo_x;
    mag_y    = (run_length == '0) ? '0 : quo_y;
    pt_x     = neg_x ? origin_x - mag_x : origin_x + mag_x;
    pt_y     = neg_y ? origin_y - mag_y : origin_y + mag_y;
    y_wide   = {{HEIGHT_BITS{1'b0}}, pt_y};
    h_wide   = {{CB{1'b0}}, screen_height};
    row_wide = h_wide - CW'(1) - y_wide;
  end

  always_ff @(posedge clk) begin
    if (state == ST_POS) begin
      pos_x   <= pt_x;
      pos_inb <= y_wide < h_wide;
      pos_row <= row_wide[HEIGHT_BITS-1:0];
    end
  end

  // address and output register
  logic [RB-1:0]        row_off;
  logic [ADDR_BITS-1:0] col_off, addr;

  always_comb begin
    row_off = {{STRIDE_BITS{1'b0}}, pos_row} * {{HEIGHT_BITS{1'b0}}, row_stride};
    col_off = {{(ADDR_BITS-CB-2){1'b0}}, pos_x, 2'b00};
    addr    = pos_inb ? col_off + row_off[ADDR_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      byte_address <= addr;
      pixel_word   <= color_word;
      in_bounds    <= pos_inb;
      last_pixel   <= last_r;
    end
  end

endmodule

// ----- sv/dlpw_checker.sv -----
// port-level checks of the line pixel writer and their bind
module dlpw_checker import dlpw_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      req_type,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ADDR_BITS-1:0]      byte_address,
  input logic [WORD_BITS-1:0]      pixel_word,
  input logic                      in_bounds,
  input logic                      last_pixel
);

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_address) &&
      $stable(pixel_word) && $stable(in_bounds) && $stable(last_pixel))
    else $error("stalled pixel write changed");

  // a dropped row carries a zero address
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_bounds |-> byte_address == '0)
    else $error("out of bounds write with nonzero address");

  // the block is ready again in the cycle after a line command is taken
  a_line_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_LINE) |=> in_ready)
    else $error("not ready after line command");

  // no pixel can appear right after a transfer in
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("pixel appeared one cycle after request");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind dda_line_pixel_writer dlpw_checker u_dlpw_checker (.*);
